/* rtl/dsaf_pkg.sv */
// Package for the one-tap ADPCM frame decoder.
// Holds the frame geometry, the predictor coefficient table and the MAC request type.
// No dependencies.
`default_nettype none

package dsaf_pkg;

  localparam int FrameBytes = 8;
  localparam int PosW       = $clog2(FrameBytes);
  localparam int HistW      = 32;
  localparam int CoefW      = 18;
  localparam int NibW       = 4;
  localparam int ShiftW     = 4;
  localparam int SampleW    = 16;

  // Largest header shift; header high nibbles at or above this give no shift.
  localparam logic [ShiftW-1:0] MaxShift = ShiftW'(12);

  typedef struct packed {
    logic [NibW-1:0]   nibble;
    logic [ShiftW-1:0] shift;
    logic [3:0]        coef_sel;
    logic [HistW-1:0]  history;
  } mac_req_t;

  // Unsigned Q16 predictor coefficients.
  function automatic logic [CoefW-1:0] coef_lookup(input logic [3:0] sel);
    logic [CoefW-1:0] c;
    c = '0;
    case (sel)
      4'd0:    c = 18'h00000;
      4'd1:    c = 18'h01999;
      4'd2:    c = 18'h03333;
      4'd3:    c = 18'h04CCC;
      4'd4:    c = 18'h06666;
      4'd5:    c = 18'h08000;
      4'd6:    c = 18'h09999;
      4'd7:    c = 18'h0B333;
      4'd8:    c = 18'h0CCCC;
      4'd9:    c = 18'h0E666;
      4'd10:   c = 18'h10000;
      4'd11:   c = 18'h11999;
      4'd12:   c = 18'h13333;
      4'd13:   c = 18'h18000;
      4'd14:   c = 18'h1CCCC;
      4'd15:   c = 18'h21999;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/dsaf_mac.sv */
// Prediction datapath: scales one nibble and adds the history times the coefficient.
// Depends on dsaf_pkg for the request type and the coefficient table.
`default_nettype none

module dsaf_mac (
  input  dsaf_pkg::mac_req_t                req_i,
  output logic [dsaf_pkg::HistW-1:0]        sum_o
);
  import dsaf_pkg::*;

  logic signed [SampleW-1:0]       nib_placed;
  logic signed [SampleW-1:0]       nib_scaled;
  logic signed [HistW-1:0]         nib_ext;
  logic signed [CoefW:0]           coef_s;
  logic signed [HistW+CoefW:0]     prod;
  logic [HistW-1:0]                pred;

  always_comb begin
    // The nibble sits at bits 15:12 and is shifted down with its sign.
    nib_placed = {req_i.nibble, 12'b0};
    nib_scaled = nib_placed >>> req_i.shift;
    nib_ext    = HistW'(nib_scaled);
    coef_s     = $signed({1'b0, coef_lookup(req_i.coef_sel)});
    prod       = $signed(req_i.history) * coef_s;
    pred       = prod[HistW+15:16];
    sum_o      = pred + nib_ext;
  end

endmodule

`default_nettype wire

/* rtl/dsaf_frame_ctrl.sv */
// Frame tracking: header decode, byte position and nibble phase for the decoder.
// Depends on dsaf_pkg for the frame geometry and shift limits.
`default_nettype none

module dsaf_frame_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          word_valid_i,
  input  logic [7:0]                    word_byte_i,
  input  logic                          word_start_i,
  input  logic                          out_free_i,
  output logic                          consume_o,
  output logic                          emit_o,
  output logic                          phase_o,
  output logic [3:0]                    coef_sel_o,
  output logic [dsaf_pkg::ShiftW-1:0]   shift_o
);
  import dsaf_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d;
  logic              phase_q, phase_d;
  logic [3:0]        coef_q, coef_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic              is_header;
  logic [3:0]        hi_nib;

  assign is_header = word_start_i || (pos_q == '0);
  assign hi_nib    = word_byte_i[7:4];
  assign emit_o    = word_valid_i && !is_header && out_free_i;
  assign consume_o = word_valid_i && (is_header || (phase_q && out_free_i));

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    coef_d  = coef_q;
    shift_d = shift_q;
    if (word_valid_i && is_header) begin
      coef_d  = word_byte_i[3:0];
      shift_d = (hi_nib >= MaxShift) ? '0 : MaxShift - hi_nib;
      pos_d   = PosW'(1);
      phase_d = 1'b0;
    end else if (emit_o) begin
      phase_d = !phase_q;
      if (phase_q) begin
        pos_d = (pos_q == PosW'(FrameBytes - 1)) ? '0 : pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= 1'b0;
      coef_q  <= '0;
      shift_q <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      coef_q  <= coef_d;
      shift_q <= shift_d;
    end
  end

  assign phase_o    = phase_q;
  assign coef_sel_o = coef_q;
  assign shift_o    = shift_q;

endmodule

`default_nettype wire

/* rtl/dsa_adpcm_frame_decoder_top.sv */
// Top level of the one-tap ADPCM frame decoder.
// Depends on dsaf_pkg, dsaf_frame_ctrl and dsaf_mac.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-----------------------------------
//  input   | in_valid_i  | in_stall_o   | data_byte_i, frame_start_i
//  output  | out_valid_o | out_stall_i  | pcm_sample_o, last_of_byte_o
//
// A header word is consumed from the input register without giving a sample; a data
// word gives two samples, one per nibble, which go through the single MAC path in turn
// since each depends on the history the previous one leaves.
// The input register takes a new word while results still wait in the output
// register. Reset clears the history, frame position and coefficient state.
// A stall on the output holds the sample register and then the input side.
`default_nettype none

module dsa_adpcm_frame_decoder_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 frame_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dsaf_pkg::SampleW-1:0]  pcm_sample_o,
  output logic                                 last_of_byte_o
);
  import dsaf_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [7:0]        byte_q;
  logic              start_q;
  logic              in_load;

  logic              out_valid_q, out_valid_d;
  logic [SampleW-1:0] pcm_q;
  logic              last_q;
  logic              out_free;

  logic [HistW-1:0]  hist_q;
  logic [HistW-1:0]  sum;

  logic              consume;
  logic              emit;
  logic              phase;
  logic [3:0]        coef_sel;
  logic [ShiftW-1:0] shift;
  mac_req_t          mac_req;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !consume;
  assign in_load    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_load ? 1'b1 : (consume ? 1'b0 : in_valid_q);
  assign out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  dsaf_frame_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (in_valid_q),
    .word_byte_i  (byte_q),
    .word_start_i (start_q),
    .out_free_i   (out_free),
    .consume_o    (consume),
    .emit_o       (emit),
    .phase_o      (phase),
    .coef_sel_o   (coef_sel),
    .shift_o      (shift)
  );

  always_comb begin
    mac_req.nibble   = phase ? byte_q[3:0] : byte_q[7:4];
    mac_req.shift    = shift;
    mac_req.coef_sel = coef_sel;
    mac_req.history  = hist_q;
  end

  dsaf_mac u_mac (
    .req_i (mac_req),
    .sum_o (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        hist_q <= sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      byte_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
    if (emit) begin
      pcm_q  <= {sum[SampleW-3:0], 2'b00};
      last_q <= phase;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pcm_sample_o   = $signed(pcm_q);
  assign last_of_byte_o = last_q;

endmodule

`default_nettype wire
